/* rtl/core/tpq_pkg.sv */
// ============================================================================
// tpq_pkg
// Shared types and constants for the three-class priority queue: field
// widths, status and class codes, and the controller/datapath interface.
// ============================================================================
package tpq_pkg;

    localparam int TAG_W        = 16;
    localparam int CLASS_W      = 2;
    localparam int STATUS_W     = 3;
    localparam int SEQ_W        = 16;
    localparam int NUM_CLASSES  = 3;
    localparam int CAPACITY_DEF = 64;
    localparam int TAG_BITS_DEF = 16;

    localparam logic CMD_ENQ = 1'b0;
    localparam logic CMD_DEQ = 1'b1;

    localparam logic [CLASS_W-1:0] CLASS_NONE   = 2'd0;
    localparam logic [CLASS_W-1:0] CLASS_LOW    = 2'd1;
    localparam logic [CLASS_W-1:0] CLASS_MEDIUM = 2'd2;
    localparam logic [CLASS_W-1:0] CLASS_HIGH   = 2'd3;

    typedef enum logic [STATUS_W-1:0] {
        ST_QUEUED  = 3'd0,
        ST_SERVED  = 3'd1,
        ST_INVALID = 3'd2,
        ST_EMPTY   = 3'd3,
        ST_FULL    = 3'd4
    } status_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    do_enq;     // store the accepted entry
        logic    do_deq;     // pop the head of the highest class, start read
        logic    load_now;   // load an immediate status result
        status_t now_code;   // code for an immediate result
        logic    load_read;  // load the served entry from the read data
    } ctrl_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic invalid;  // class code of the offered item is invalid
        logic full;     // queue holds its full capacity
        logic empty;    // queue holds no entries
    } stat_t;

endpackage

/* rtl/core/three_class_priority_fifo_queue_top.sv */
// ============================================================================
// three_class_priority_fifo_queue_top
// Bounded strict-priority queue with three classes and FIFO order per class.
// ============================================================================
// Usage:
//   Input channel (in_valid / in_stall) carries one command per transfer:
//   command 0 enqueues entry_tag under class_code, command 1 dequeues the
//   oldest entry of the highest class present. Every input transfer yields
//   exactly one output transfer (out_valid / out_stall) carrying status,
//   served_tag, served_class and served_sequence.
//   Enqueue, invalid-class, full and empty results appear in the output
//   register in the cycle after the input transfer. A served dequeue goes
//   through the registered read of the entry memory, then the output
//   register; in_stall is high during that read. Items that need no memory
//   read are taken one per cycle while the receiver does not stall.
//   The block takes a new item while the previous result is being taken;
//   if the receiver stalls a waiting result, in_stall rises until it drains,
//   and the result holds steady meanwhile.
//   Reset clears the queue to empty and the arrival counter to zero; the
//   entry memory itself is not cleared and needs no clearing pass.
// ============================================================================
module three_class_priority_fifo_queue_top
    import tpq_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int TAG_BITS = TAG_BITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                command,
    input  logic [CLASS_W-1:0]  class_code,
    input  logic [TAG_W-1:0]    entry_tag,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [STATUS_W-1:0] status,
    output logic [TAG_W-1:0]    served_tag,
    output logic [CLASS_W-1:0]  served_class,
    output logic [SEQ_W-1:0]    served_sequence
);

    ctrl_t ctrl;
    stat_t stat;

    // Controller sequences each item; datapath holds all queue state.
    tpq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .command   (command),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .ctrl      (ctrl)
    );

    tpq_dp #(
        .CAPACITY (CAPACITY),
        .TAG_BITS (TAG_BITS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .class_code      (class_code),
        .entry_tag       (entry_tag),
        .ctrl            (ctrl),
        .stat            (stat),
        .status          (status),
        .served_tag      (served_tag),
        .served_class    (served_class),
        .served_sequence (served_sequence)
    );

    // A store and a pop never happen for the same item.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(ctrl.do_enq && ctrl.do_deq))
        else $error("enqueue and dequeue issued together");

    // A pop blocks the input until its entry has been read out.
    assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.do_deq |=> in_stall)
        else $error("input not held during dequeue read");

    // A pop delivers a served result after the memory read register and the output register.
    assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.do_deq |=> ##1 (out_valid && (status == ST_SERVED)))
        else $error("served result missing after dequeue");

    // A served entry always carries a real class.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == ST_SERVED)) |-> (served_class != CLASS_NONE))
        else $error("served entry without class");

endmodule

/* rtl/core/tpq_ctrl.sv */
// ============================================================================
// tpq_ctrl
// Controller: decides each accepted item, sequences the dequeue read
// and owns the output valid flag.
// ============================================================================
module tpq_ctrl
    import tpq_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    input  logic  command,
    output logic  in_stall,
    output logic  out_valid,
    input  logic  out_stall,
    input  stat_t stat,
    output ctrl_t ctrl
);

    typedef enum logic {
        FSM_IDLE,
        FSM_READ
    } fsm_t;

    fsm_t state_reg;
    fsm_t state_next;
    logic out_valid_reg;
    logic out_valid_next;
    logic accept;

    // The output register must be free or draining before a new item enters.
    assign in_stall  = (state_reg == FSM_READ) || (out_valid_reg && out_stall);
    assign accept    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        ctrl.do_enq    = accept && (command == CMD_ENQ) && !stat.invalid && !stat.full;
        ctrl.do_deq    = accept && (command == CMD_DEQ) && !stat.empty;
        ctrl.load_now  = accept && !ctrl.do_deq;
        ctrl.load_read = (state_reg == FSM_READ);
        if (command == CMD_DEQ)
        begin
            ctrl.now_code = ST_EMPTY;
        end
        else if (stat.invalid)
        begin
            ctrl.now_code = ST_INVALID;
        end
        else if (stat.full)
        begin
            ctrl.now_code = ST_FULL;
        end
        else
        begin
            ctrl.now_code = ST_QUEUED;
        end
    end

    always_comb
    begin
        case (state_reg)
            FSM_IDLE: state_next = ctrl.do_deq ? FSM_READ : FSM_IDLE;
            FSM_READ: state_next = FSM_IDLE;
            default:  state_next = FSM_IDLE;
        endcase

        if (ctrl.load_now || ctrl.load_read)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= FSM_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

/* rtl/core/tpq_dp.sv */
// ============================================================================
// tpq_dp
// Datapath: one entry memory split into a ring per class, per-class
// pointers and counts, occupancy, arrival counter and the result register.
// ============================================================================
module tpq_dp
    import tpq_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int TAG_BITS = TAG_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [CLASS_W-1:0] class_code,
    input  logic [TAG_W-1:0]   entry_tag,
    input  ctrl_t              ctrl,
    output stat_t              stat,
    output logic [STATUS_W-1:0] status,
    output logic [TAG_W-1:0]   served_tag,
    output logic [CLASS_W-1:0] served_class,
    output logic [SEQ_W-1:0]   served_sequence
);

    localparam int STORE_W = (TAG_BITS < TAG_W) ? TAG_BITS : TAG_W;
    localparam int ENT_W   = STORE_W + SEQ_W;
    localparam int PTR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int OCC_W   = $clog2(CAPACITY + 1);
    localparam int DEPTH   = NUM_CLASSES * CAPACITY;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int IDX_W   = $clog2(NUM_CLASSES);

    logic [ENT_W-1:0]   mem [DEPTH];
    logic [ENT_W-1:0]   rd_data_reg;

    logic [PTR_W-1:0]   wr_ptr_reg [NUM_CLASSES];
    logic [PTR_W-1:0]   rd_ptr_reg [NUM_CLASSES];
    logic [OCC_W-1:0]   cnt_reg    [NUM_CLASSES];
    logic [OCC_W-1:0]   occ_reg;
    logic [SEQ_W-1:0]   arrival_reg;
    logic [CLASS_W-1:0] deq_cls_reg;

    logic [STATUS_W-1:0] status_reg;
    logic [TAG_W-1:0]    tag_reg;
    logic [CLASS_W-1:0]  class_reg;
    logic [SEQ_W-1:0]    seq_reg;

    logic [IDX_W-1:0]   enq_idx;
    logic [IDX_W-1:0]   deq_idx;
    logic [ADDR_W-1:0]  wr_addr;
    logic [ADDR_W-1:0]  rd_addr;

    assign stat.invalid = (class_code == CLASS_NONE);
    assign stat.full    = (occ_reg == OCC_W'(CAPACITY));
    assign stat.empty   = (occ_reg == '0);

    always_comb
    begin
        case (class_code)
            CLASS_HIGH:   enq_idx = IDX_W'(2);
            CLASS_MEDIUM: enq_idx = IDX_W'(1);
            default:      enq_idx = IDX_W'(0);
        endcase

        // Strict priority: the highest class that holds an entry.
        if (cnt_reg[2] != '0)
        begin
            deq_idx = IDX_W'(2);
        end
        else if (cnt_reg[1] != '0)
        begin
            deq_idx = IDX_W'(1);
        end
        else
        begin
            deq_idx = IDX_W'(0);
        end

        wr_addr = ADDR_W'(enq_idx) * ADDR_W'(CAPACITY) + ADDR_W'(wr_ptr_reg[enq_idx]);
        rd_addr = ADDR_W'(deq_idx) * ADDR_W'(CAPACITY) + ADDR_W'(rd_ptr_reg[deq_idx]);
    end

    // Entry memory: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (ctrl.do_enq)
        begin
            mem[wr_addr] <= {arrival_reg, entry_tag[STORE_W-1:0]};
        end
        if (ctrl.do_deq)
        begin
            rd_data_reg <= mem[rd_addr];
            deq_cls_reg <= CLASS_W'(deq_idx) + CLASS_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < NUM_CLASSES; c++)
            begin
                wr_ptr_reg[c] <= '0;
                rd_ptr_reg[c] <= '0;
                cnt_reg[c]    <= '0;
            end
            occ_reg     <= '0;
            arrival_reg <= '0;
        end
        else
        begin
            if (ctrl.do_enq)
            begin
                wr_ptr_reg[enq_idx] <= (wr_ptr_reg[enq_idx] == PTR_W'(CAPACITY - 1)) ?
                                       '0 : wr_ptr_reg[enq_idx] + PTR_W'(1);
                cnt_reg[enq_idx]    <= cnt_reg[enq_idx] + OCC_W'(1);
                occ_reg             <= occ_reg + OCC_W'(1);
                arrival_reg         <= arrival_reg + SEQ_W'(1);
            end
            if (ctrl.do_deq)
            begin
                rd_ptr_reg[deq_idx] <= (rd_ptr_reg[deq_idx] == PTR_W'(CAPACITY - 1)) ?
                                       '0 : rd_ptr_reg[deq_idx] + PTR_W'(1);
                cnt_reg[deq_idx]    <= cnt_reg[deq_idx] - OCC_W'(1);
                occ_reg             <= occ_reg - OCC_W'(1);
            end
        end
    end

    // Result register.
    always_ff @(posedge clk)
    begin
        if (ctrl.load_now)
        begin
            status_reg <= ctrl.now_code;
            tag_reg    <= '0;
            class_reg  <= CLASS_NONE;
            seq_reg    <= '0;
        end
        else if (ctrl.load_read)
        begin
            status_reg <= ST_SERVED;
            tag_reg    <= TAG_W'(rd_data_reg[STORE_W-1:0]);
            class_reg  <= deq_cls_reg;
            seq_reg    <= rd_data_reg[ENT_W-1:STORE_W];
        end
    end

    assign status          = status_reg;
    assign served_tag      = tag_reg;
    assign served_class    = class_reg;
    assign served_sequence = seq_reg;

endmodule

/* sim/three_class_priority_fifo_queue_top_test.sv */
// ============================================================================
// three_class_priority_fifo_queue_top_test
// Self-checking testbench for the three-class priority queue. Commands are
// driven through the valid/stall input channel, and a scoreboard keeps its
// own copy of the queue to predict every status result. Each result taken
// from the output channel is checked field by field. Both sides idle at
// random, and long receiver hold-offs fill the block until it stalls
// its input.
// ============================================================================
module three_class_priority_fifo_queue_top_test;

    import tpq_pkg::*;

    // The run is cut off well past the slowest correct run.
    localparam int LIMIT_CYCLES = 200_000;
    localparam int HOLD_CYCLES  = 200;
    localparam int RANDOM_ITEMS = 550;
    localparam int DRAIN_LIMIT  = 5000;

    // ------------------------------------------------------------------------
    // Scoreboard: a behavioral copy of the queue plus the list of results
    // that are still due from the block.
    // ------------------------------------------------------------------------
    class queue_scoreboard;
        typedef struct {
            logic [TAG_W-1:0]   tag;
            logic [CLASS_W-1:0] cls;
            logic [SEQ_W-1:0]   seq;
        } entry_t;

        typedef struct {
            status_t            code;
            logic [TAG_W-1:0]   tag;
            logic [CLASS_W-1:0] cls;
            logic [SEQ_W-1:0]   seq;
        } result_t;

        entry_t           stored[$];   // entries in arrival order
        result_t          awaited[$];  // results not yet seen at the output
        logic [SEQ_W-1:0] arrival;     // number given to the next stored entry
        int               mismatches;
        int               results_seen;

        function new();
            arrival      = '0;
            mismatches   = 0;
            results_seen = 0;
        endfunction

        // Works out the status of one accepted command and updates the
        // queue copy the same way the block must.
        function void note_transfer(input logic cmd, input logic [CLASS_W-1:0] cls,
                                    input logic [TAG_W-1:0] tag);
            result_t r;
            entry_t  e;
            int      pick;
            r.code = ST_QUEUED;
            r.tag  = '0;
            r.cls  = CLASS_NONE;
            r.seq  = '0;
            if (cmd == CMD_ENQ)
            begin
                // The class check comes before the room check.
                if (cls == CLASS_NONE)
                    r.code = ST_INVALID;
                else if (stored.size() >= CAPACITY_DEF)
                    r.code = ST_FULL;
                else
                begin
                    e.tag = tag;
                    e.cls = cls;
                    e.seq = arrival;
                    stored.push_back(e);
                    arrival = arrival + 1'b1;
                end
            end
            else if (stored.size() == 0)
                r.code = ST_EMPTY;
            else
            begin
                // Oldest entry of the highest class present; storage order
                // decides, never the arrival number.
                pick = 0;
                for (int i = 1; i < stored.size(); i++)
                    if (stored[i].cls > stored[pick].cls)
                        pick = i;
                r.code = ST_SERVED;
                r.tag  = stored[pick].tag;
                r.cls  = stored[pick].cls;
                r.seq  = stored[pick].seq;
                stored.delete(pick);
            end
            awaited.push_back(r);
        endfunction

        task report_mismatch(input string what, input logic [31:0] got,
                             input logic [31:0] want);
            mismatches++;
            if (mismatches <= 40)
                $display("mismatch at result %0d: %s got %0h expected %0h",
                         results_seen, what, got, want);
        endtask

        task check_result(input logic [STATUS_W-1:0] st, input logic [TAG_W-1:0] tag,
                          input logic [CLASS_W-1:0] cls, input logic [SEQ_W-1:0] seq);
            result_t want;
            results_seen++;
            if (awaited.size() == 0)
            begin
                report_mismatch("result with nothing pending, status", st, 0);
                return;
            end
            want = awaited.pop_front();
            if (st !== want.code)
                report_mismatch("status", st, want.code);
            if (tag !== want.tag)
                report_mismatch("served_tag", tag, want.tag);
            if (cls !== want.cls)
                report_mismatch("served_class", cls, want.cls);
            if (seq !== want.seq)
                report_mismatch("served_sequence", seq, want.seq);
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Block under test and its signals.
    // ------------------------------------------------------------------------
    logic                clk = 1'b0;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic                command;
    logic [CLASS_W-1:0]  class_code;
    logic [TAG_W-1:0]    entry_tag;
    logic                out_valid;
    logic                out_stall;
    logic [STATUS_W-1:0] status;
    logic [TAG_W-1:0]    served_tag;
    logic [CLASS_W-1:0]  served_class;
    logic [SEQ_W-1:0]    served_sequence;

    queue_scoreboard sb;

    // Flags shared by the driving processes.
    bit tx_bursty = 1'b1;  // sender inserts gaps between bursts
    bit rx_quiet  = 1'b0;  // receiver never stalls
    bit hold_req  = 1'b0;  // receiver is asked for one long hold-off
    int burst_left = 0;

    three_class_priority_fifo_queue_top u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .command         (command),
        .class_code      (class_code),
        .entry_tag       (entry_tag),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .status          (status),
        .served_tag      (served_tag),
        .served_class    (served_class),
        .served_sequence (served_sequence)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Sender. Each call offers one command and returns once its transfer has
    // happened. Inputs change only at the falling edge; acceptance is seen at
    // the rising edge. In bursty mode the sender rests between bursts of
    // random length, some of them long.
    // ------------------------------------------------------------------------
    task automatic send_item(input logic cmd, input logic [CLASS_W-1:0] cls,
                             input logic [TAG_W-1:0] tag);
        int gap;
        @(negedge clk);
        if (tx_bursty && burst_left == 0)
        begin
            gap = $urandom_range(1, 6);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 16);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        if (burst_left > 0)
            burst_left--;
        in_valid   <= 1'b1;
        command    <= cmd;
        class_code <= cls;
        entry_tag  <= tag;
        // The payload stays put until the block takes it.
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_transfer(cmd, cls, tag);
    endtask

    // Valid classes are common; the invalid code shows up now and then.
    function automatic logic [CLASS_W-1:0] pick_class();
        if ($urandom_range(0, 11) == 0)
            return CLASS_NONE;
        return CLASS_W'($urandom_range(1, 3));
    endfunction

    function automatic logic [TAG_W-1:0] pick_tag();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return TAG_W'($urandom);
        endcase
    endfunction

    task automatic send_random(input int enq_pct);
        if ($urandom_range(0, 99) < enq_pct)
            send_item(CMD_ENQ, pick_class(), pick_tag());
        else
            // Class and tag are don't-care on a dequeue, so they carry noise.
            send_item(CMD_DEQ, CLASS_W'($urandom), TAG_W'($urandom));
    endtask

    // ------------------------------------------------------------------------
    // Receiver. It stalls on a pattern of its own: runs with no stall, runs
    // with light stalls and runs with heavy stalls. When a hold-off is asked
    // for, it keeps the output stalled for a hold-off whose length is set by
    // HOLD_CYCLES, while the sender keeps offering, so that the block backs
    // up into in_stall.
    // ------------------------------------------------------------------------
    initial
    begin : rx_pattern
        int run_len;
        int stall_pct;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_req)
            begin
                @(negedge clk);
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                run_len = $urandom_range(4, 40);
                case ($urandom_range(0, 2))
                    0:       stall_pct = 0;
                    1:       stall_pct = 25;
                    default: stall_pct = 70;
                endcase
                for (int i = 0; i < run_len && !hold_req; i++)
                begin
                    @(negedge clk);
                    out_stall <= !rx_quiet && ($urandom_range(0, 99) < stall_pct);
                end
            end
        end
    end

    // Results are taken at the rising edge when valid is high and the
    // receiver is not stalling.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(status, served_tag, served_class, served_sequence);
    end

    initial
    begin : run_limit
        #(LIMIT_CYCLES * 8);
        $display("== FAIL ==");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus.
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        int enq_pct;
        int seg_len;
        int sent;
        int waited;
        sb         = new();
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        command    = CMD_ENQ;
        class_code = CLASS_NONE;
        entry_tag  = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part: invalid class and dequeue on an empty queue, then a
        // mix of classes with extreme tags that must come back highest class
        // first and oldest first within a class.
        send_item(CMD_ENQ, CLASS_NONE,   16'hFFFF);
        send_item(CMD_DEQ, CLASS_HIGH,   16'hFFFF);
        send_item(CMD_ENQ, CLASS_LOW,    16'h0000);
        send_item(CMD_ENQ, CLASS_MEDIUM, 16'hFFFF);
        send_item(CMD_ENQ, CLASS_HIGH,   16'h8001);
        send_item(CMD_ENQ, CLASS_LOW,    16'h7FFE);
        send_item(CMD_ENQ, CLASS_NONE,   16'h0000);
        send_item(CMD_ENQ, CLASS_HIGH,   16'h0001);
        send_item(CMD_ENQ, CLASS_MEDIUM, 16'h5A5A);
        repeat (6) send_item(CMD_DEQ, CLASS_NONE, 16'h0000);
        send_item(CMD_DEQ, CLASS_LOW, 16'hA5A5);

        // Fill to capacity under a long receiver hold-off, then try to go
        // past it: a valid class reports full, the invalid code still
        // reports invalid. Draining two past empty checks the empty status.
        hold_req = 1'b1;
        repeat (CAPACITY_DEF) send_item(CMD_ENQ, CLASS_W'($urandom_range(1, 3)), pick_tag());
        send_item(CMD_ENQ, CLASS_HIGH, 16'hFFFF);
        send_item(CMD_ENQ, CLASS_NONE, 16'h1234);
        send_item(CMD_ENQ, CLASS_LOW,  16'h0000);
        repeat (CAPACITY_DEF + 2) send_item(CMD_DEQ, CLASS_W'($urandom), TAG_W'($urandom));

        // Random part: segments with different enqueue biases so the queue
        // swings between empty and full. Some segments start with another
        // hold-off.
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 2))
                0:       enq_pct = 25;
                1:       enq_pct = 50;
                default: enq_pct = 85;
            endcase
            seg_len = $urandom_range(30, 120);
            if ($urandom_range(0, 7) == 0)
                hold_req = 1'b1;
            repeat (seg_len) send_random(enq_pct);
            sent += seg_len;
        end

        @(negedge clk);
        in_valid <= 1'b0;

        // Wait for every pending result, then keep watching so that any stray
        // output would still be caught.
        waited = 0;
        while (sb.awaited.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (8) @(posedge clk);
        if (sb.awaited.size() != 0)
            sb.report_mismatch("results never delivered, count", sb.awaited.size(), 0);

        if (sb.mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
